@@ src/rcit_pkg.sv @@
package rcit_pkg;

    // Field widths of the channel words.
    localparam int KIND_W   = 1;
    localparam int ID_W     = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;

    // Default table geometry.
    localparam int SLOTS_DEF      = 64;
    localparam int ID_BITS_DEF    = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND       = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_FULL        = 3'd2,
        ST_SATURATED   = 3'd3,
        ST_RELEASED    = 3'd4,
        ST_FREED       = 3'd5,
        ST_BAD_RELEASE = 3'd6
    } status_t;

endpackage

@@ src/rcit_req_if.sv @@
interface rcit_req_if;
    import rcit_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     user_id;
    logic [SLOT_W-1:0]   slot_in;

    modport source (output valid, output kind, output user_id, output slot_in, input ready);
    modport sink   (input valid, input kind, input user_id, input slot_in, output ready);

endinterface

@@ src/rcit_rsp_if.sv @@
interface rcit_rsp_if;
    import rcit_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [SLOT_W-1:0]   slot_out;
    logic [COUNT_W-1:0]  count_out;

    modport source (output valid, output status, output slot_out, output count_out, input ready);
    modport sink   (input valid, input status, input slot_out, input count_out, output ready);

endinterface

@@ src/rcit_store.sv @@
module rcit_store #(
    parameter int DEPTH = rcit_pkg::SLOTS_DEF,
    parameter int WIDTH = rcit_pkg::ID_BITS_DEF + rcit_pkg::COUNT_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/refcounted_id_table.sv @@
// Channel  Direction  Word
// req      in         kind, user_id, slot_in
// rsp      out        status, slot_out, count_out
//
// An acquire walks the entries in slot order through the single read port
// of the entry memory and one ID comparator, stopping at the first match.
// A release reads and checks the named slot, then updates it if in use.
// After reset a clearing pass rewrites every entry; req is not ready
// during it. The result sits in an output register, so while rsp stalls,
// at most the following item runs and then waits in S_EMIT.
module refcounted_id_table #(
    parameter int SLOTS      = rcit_pkg::SLOTS_DEF,
    parameter int ID_BITS    = rcit_pkg::ID_BITS_DEF,
    parameter int COUNT_BITS = rcit_pkg::COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rcit_req_if.sink     req,
    rcit_rsp_if.source   rsp
);
    import rcit_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = ID_BITS + COUNT_BITS;
    localparam int RW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
    localparam logic [AW-1:0]         LAST    = AW'(SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_RLOOK = 6'b001000,
        S_RCHK  = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          scan_reg, scan_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   have_free_reg, have_free_next;
    logic                   out_valid_reg, out_valid_next;

    logic [AW-1:0]          chk_reg, chk_next;
    logic [AW-1:0]          free_reg, free_next;
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    status_t                res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [COUNT_W-1:0]     res_count_reg, res_count_next;
    status_t                out_status_reg, out_status_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [EW-1:0]          mem_rdata;

    logic [ID_BITS-1:0]     rd_id;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [COUNT_BITS-1:0]  cnt_dec;
    logic                   hit;
    logic                   in_range;
    logic                   accept;
    logic [AW-1:0]          ins_slot;

    rcit_store #(
        .DEPTH (SLOTS),
        .WIDTH (EW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_id    = mem_rdata[EW-1:COUNT_BITS];
    assign rd_cnt   = mem_rdata[COUNT_BITS-1:0];
    assign cnt_inc  = rd_cnt + CNT_ONE;
    assign cnt_dec  = rd_cnt - CNT_ONE;
    // An entry is in use exactly while its count is nonzero.
    assign hit      = (rd_cnt != '0) && (rd_id == id_reg);
    assign in_range = RW'(slot_reg) < RW'(SLOTS);
    assign ins_slot = have_free_reg ? free_reg : chk_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.slot_out  = out_slot_reg;
    assign rsp.count_out = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        chk_vld_next    = chk_vld_reg;
        have_free_next  = have_free_reg;
        out_valid_next  = out_valid_reg;
        chk_next        = chk_reg;
        free_next       = free_reg;
        id_next         = id_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_reg;
        mem_wdata       = '0;
        mem_raddr       = scan_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = (scan_reg == '0) ? {{ID_BITS{1'b0}}, CNT_ONE} : '0;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    id_next        = req.user_id[ID_BITS-1:0];
                    slot_next      = req.slot_in;
                    scan_next      = '0;
                    chk_vld_next   = 1'b0;
                    have_free_next = 1'b0;
                    state_next     = (req.kind == KIND_RELEASE) ? S_RLOOK : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Read of scan_reg is issued now; chk_reg's data is on the port.
                mem_raddr    = scan_reg;
                scan_next    = scan_reg + 1'b1;
                chk_next     = scan_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg)
                begin
                    if (hit)
                    begin
                        res_slot_next = SLOT_W'(chk_reg);
                        if (rd_cnt == CNT_MAX)
                        begin
                            res_status_next = ST_SATURATED;
                            res_count_next  = COUNT_W'(rd_cnt);
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = chk_reg;
                            mem_wdata       = {rd_id, cnt_inc};
                            res_status_next = ST_FOUND;
                            res_count_next  = COUNT_W'(cnt_inc);
                        end
                        state_next = S_EMIT;
                    end
                    else if (chk_reg == LAST)
                    begin
                        if (have_free_reg || (rd_cnt == '0))
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = ins_slot;
                            mem_wdata       = {id_reg, CNT_ONE};
                            res_status_next = ST_INSERTED;
                            res_slot_next   = SLOT_W'(ins_slot);
                            res_count_next  = COUNT_W'(CNT_ONE);
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                            res_slot_next   = '0;
                            res_count_next  = '0;
                        end
                        state_next = S_EMIT;
                    end
                    else if ((rd_cnt == '0) && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = chk_reg;
                    end
                end
            end

            S_RLOOK:
            begin
                mem_raddr  = AW'(slot_reg);
                state_next = S_RCHK;
            end

            S_RCHK:
            begin
                res_slot_next = slot_reg;
                if (!in_range || (rd_cnt == '0))
                begin
                    res_status_next = ST_BAD_RELEASE;
                    res_count_next  = '0;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(slot_reg);
                    mem_wdata = {rd_id, cnt_dec};
                    if (cnt_dec == '0)
                    begin
                        res_status_next = ST_FREED;
                        res_count_next  = '0;
                    end
                    else
                    begin
                        res_status_next = ST_RELEASED;
                        res_count_next  = COUNT_W'(cnt_dec);
                    end
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                scan_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            have_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            chk_vld_reg   <= chk_vld_next;
            have_free_reg <= have_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg        <= chk_next;
        free_reg       <= free_next;
        id_reg         <= id_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
    end

`ifndef SYNTH
    // A new result word only appears after the emit step of the sequencer.
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("result word appeared outside the emit step");

    // The entry memory is written only by the clearing pass, a scan or a release.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_SCAN || state_reg == S_RCHK))
        else $error("entry memory written in an unexpected state");

    // An inserted slot always starts at one; freed, full and bad results carry zero.
    a_result_counts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |->
            (rsp.status != ST_INSERTED || rsp.count_out == COUNT_W'(1)) &&
            ((rsp.status != ST_FREED && rsp.status != ST_FULL &&
              rsp.status != ST_BAD_RELEASE) || rsp.count_out == '0))
        else $error("result count does not fit its status");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import rcit_pkg::*;

    localparam int          TBL_SLOTS   = SLOTS_DEF;
    localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
    localparam int          N_RANDOM    = 1850;
    localparam int          QUEUE_ROOM  = 4;
    localparam int          HOLD_CYCLES = 300;
    localparam int          POOL_N      = 24;
    // About 1870 words of at most one full table scan each, with idle gaps on both
    // sides and one long receiver hold; the limit is several times the sum.
    localparam longint      CYCLE_LIMIT = 64'd1_000_000;

    typedef enum int {IDLE_NONE, IDLE_RANDOM, IDLE_BURSTY} idle_mode_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   user_id;
        logic [SLOT_W-1:0] slot_in;
        int                gap;
        bit                wait_drain;
    } req_word_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    rcit_req_if req_ch ();
    rcit_rsp_if rsp_ch ();

    refcounted_id_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table, updated as each request word is accepted.
    logic [ID_W-1:0] tbl_id   [TBL_SLOTS];
    int unsigned     tbl_cnt  [TBL_SLOTS];
    bit              tbl_used [TBL_SLOTS];

    req_word_t  pending_q[$];
    rsp_word_t  rsp_expect_q[$];
    req_word_t  drv_word;
    logic [ID_W-1:0] id_pool [POOL_N];

    bit         req_took;
    bit         rsp_took;
    bit         head_armed;
    int         idle_left;
    int         stall_left;
    int         hold_left;
    bit         hold_req;
    idle_mode_t send_mode;
    idle_mode_t rcv_mode;

    int         err_cnt;
    int         n_checked;
    int         n_acquire;
    int         n_release;
    int         rand_words;
    int         status_seen [8];
    longint     cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_RANDOM: return $urandom_range(0, 15);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 15) : 0;
        endcase
    endfunction

    function automatic int held_slots();
        int i;
        int n;
        n = 0;
        for (i = 0; i < TBL_SLOTS; i++)
            if (tbl_used[i])
                n++;
        return n;
    endfunction

    function automatic rsp_word_t table_step(input req_word_t w);
        rsp_word_t r;
        int        i;
        int        hit;
        int        hole;
        int        s;
        hit  = -1;
        hole = -1;
        if (w.kind == KIND_ACQUIRE)
        begin
            for (i = 0; i < TBL_SLOTS; i++)
            begin
                if (hit < 0 && tbl_used[i] && tbl_id[i] == w.user_id)
                    hit = i;
                if (hole < 0 && !tbl_used[i])
                    hole = i;
            end
            if (hit >= 0)
            begin
                if (tbl_cnt[hit] >= COUNT_MAX)
                    r.status = ST_SATURATED;
                else
                begin
                    tbl_cnt[hit] = tbl_cnt[hit] + 1;
                    r.status = ST_FOUND;
                end
                r.slot  = SLOT_W'(hit);
                r.count = COUNT_W'(tbl_cnt[hit]);
            end
            else if (hole < 0)
            begin
                r.status = ST_FULL;
                r.slot   = '0;
                r.count  = '0;
            end
            else
            begin
                tbl_used[hole] = 1'b1;
                tbl_id[hole]   = w.user_id;
                tbl_cnt[hole]  = 1;
                r.status = ST_INSERTED;
                r.slot   = SLOT_W'(hole);
                r.count  = COUNT_W'(1);
            end
        end
        else
        begin
            s = int'(w.slot_in);
            r.slot = w.slot_in;
            if (s >= TBL_SLOTS || !tbl_used[s])
            begin
                r.status = ST_BAD_RELEASE;
                r.count  = '0;
            end
            else
            begin
                tbl_cnt[s] = tbl_cnt[s] - 1;
                if (tbl_cnt[s] == 0)
                begin
                    tbl_used[s] = 1'b0;
                    r.status = ST_FREED;
                    r.count  = '0;
                end
                else
                begin
                    r.status = ST_RELEASED;
                    r.count  = COUNT_W'(tbl_cnt[s]);
                end
            end
        end
        return r;
    endfunction

    // Waits for room in the pending queue, then appends one request word.
    task automatic push_word(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                             input logic [SLOT_W-1:0] s, input bit drain);
        req_word_t w;
        while (pending_q.size() >= QUEUE_ROOM)
        begin
            @(posedge clk);
            #2;
        end
        w.kind       = k;
        w.user_id    = id;
        w.slot_in    = s;
        w.gap        = idle_draw(send_mode);
        w.wait_drain = drain;
        pending_q.push_back(w);
    endtask

    task automatic push_random(input int acq_pct, input bit drain);
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] s;
        int                held[$];
        int                i;
        id = $urandom;
        s  = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
        if ($urandom_range(0, 99) < acq_pct)
        begin
            if ($urandom_range(0, 1) == 1)
                id = id_pool[$urandom_range(0, POOL_N - 1)];
            push_word(KIND_ACQUIRE, id, s, drain);
        end
        else
        begin
            // Mostly release a slot that is in use; the rest name a random slot.
            for (i = 0; i < TBL_SLOTS; i++)
                if (tbl_used[i])
                    held.push_back(i);
            if (held.size() != 0 && $urandom_range(0, 9) != 0)
                s = SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
            push_word(KIND_RELEASE, id, s, drain);
        end
        rand_words++;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (req_ch.valid && !req_took)
        begin
            // The offered word has not been taken yet; keep it on the bus.
        end
        else if (pending_q.size() == 0)
            req_ch.valid <= 1'b0;
        else
        begin
            if (!head_armed)
            begin
                idle_left  = pending_q[0].gap;
                head_armed = 1'b1;
            end
            if (idle_left > 0)
            begin
                idle_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_q[0].wait_drain && rsp_expect_q.size() != 0)
                req_ch.valid <= 1'b0;
            else
            begin
                drv_word   = pending_q.pop_front();
                head_armed = 1'b0;
                req_ch.valid   <= 1'b1;
                req_ch.kind    <= drv_word.kind;
                req_ch.user_id <= drv_word.user_id;
                req_ch.slot_in <= drv_word.slot_in;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_took)
                stall_left = idle_draw(rcv_mode);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        req_word_t w;
        rsp_word_t got;
        rsp_word_t want;
        req_took <= rst_n && req_ch.valid && req_ch.ready;
        rsp_took <= rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            w.kind       = req_ch.kind;
            w.user_id    = req_ch.user_id;
            w.slot_in    = req_ch.slot_in;
            w.gap        = 0;
            w.wait_drain = 1'b0;
            if (w.kind == KIND_ACQUIRE)
                n_acquire++;
            else
                n_release++;
            rsp_expect_q.push_back(table_step(w));
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status = rsp_ch.status;
            got.slot   = rsp_ch.slot_out;
            got.count  = rsp_ch.count_out;
            n_checked++;
            status_seen[got.status]++;
            if (rsp_expect_q.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("unexpected result word: status %0d slot %0d count %0d",
                             got.status, got.slot, got.count);
                err_cnt++;
            end
            else
            begin
                want = rsp_expect_q.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                    || got.count !== want.count)
                begin
                    if (err_cnt < 10)
                        $display("result %0d: expected status %0d slot %0d count %0d, %s %0d %0d %0d",
                                 n_checked, want.status, want.slot, want.count,
                                 "got status/slot/count", got.status, got.slot, got.count);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_cnt, rsp_expect_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int i;
        int round;
        int phase_words;
        int extra;
        rst_n          = 1'b0;
        send_mode      = IDLE_RANDOM;
        rcv_mode       = IDLE_RANDOM;
        for (i = 0; i < TBL_SLOTS; i++)
        begin
            tbl_id[i]   = '0;
            tbl_cnt[i]  = 0;
            tbl_used[i] = 1'b0;
        end
        // Slot 0 comes out of reset as the root entry.
        tbl_used[0] = 1'b1;
        tbl_cnt[0]  = 1;
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = 32'hA5A5_A5A5;
        id_pool[3] = 32'h5A5A_5A5A;
        id_pool[4] = 32'h0000_0001;
        id_pool[5] = 32'h8000_0000;
        for (i = 6; i < POOL_N; i++)
            id_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_word(KIND_ACQUIRE, 32'h0000_0000, 6'd63, 1'b0);
        push_word(KIND_ACQUIRE, 32'hFFFF_FFFF, 6'd0, 1'b0);
        push_word(KIND_ACQUIRE, 32'hFFFF_FFFF, 6'd21, 1'b0);
        push_word(KIND_RELEASE, 32'hFFFF_FFFF, 6'd63, 1'b0);
        push_word(KIND_RELEASE, 32'h0000_0000, 6'd0, 1'b0);
        push_word(KIND_RELEASE, 32'h1234_5678, 6'd0, 1'b0);
        push_word(KIND_RELEASE, 32'h0000_0000, 6'd0, 1'b0);
        // The freed root slot is the lowest hole and must be reused first.
        push_word(KIND_ACQUIRE, 32'hA5A5_A5A5, 6'd42, 1'b1);
        push_word(KIND_ACQUIRE, 32'h5A5A_5A5A, 6'd0, 1'b0);
        push_word(KIND_RELEASE, 32'h0000_0000, 6'd1, 1'b0);
        push_word(KIND_RELEASE, 32'hFFFF_FFFF, 6'd1, 1'b0);
        push_word(KIND_ACQUIRE, 32'h0000_0001, 6'd63, 1'b0);
        push_word(KIND_ACQUIRE, 32'h8000_0000, 6'd0, 1'b0);
        push_word(KIND_ACQUIRE, 32'h0000_0000, 6'd0, 1'b0);
        push_word(KIND_ACQUIRE, 32'h0000_0000, 6'd5, 1'b0);
        push_word(KIND_RELEASE, 32'h0000_0000, 6'd4, 1'b0);
        push_word(KIND_RELEASE, 32'h7FFF_FFFF, 6'd4, 1'b0);

        // Alternate filling the table until it reports full and draining it again.
        round = 0;
        while (rand_words < N_RANDOM)
        begin
            send_mode = idle_mode_t'(round % 3);
            rcv_mode  = idle_mode_t'((round + 1) % 3);
            if (round == 1)
            begin
                send_mode = IDLE_NONE;
                hold_req  = 1'b1;
            end
            push_random(85, 1'b1);
            phase_words = 1;
            extra = 0;
            while (rand_words < N_RANDOM && phase_words < 400 && extra < 12)
            begin
                push_random(85, 1'b0);
                phase_words++;
                if (held_slots() == TBL_SLOTS)
                    extra++;
            end
            phase_words = 0;
            while (rand_words < N_RANDOM && phase_words < 400 && held_slots() > 4)
            begin
                push_random(20, 1'b0);
                phase_words++;
            end
            round++;
        end

        while (pending_q.size() != 0 || req_ch.valid || rsp_expect_q.size() != 0)
        begin
            @(posedge clk);
            #2;
        end
        repeat (2 * TBL_SLOTS) @(posedge clk);

        $display("Run covered %0d acquire and %0d release words in %0d cycles, %s",
                 n_acquire, n_release, cycle_cnt,
                 "including repeated table fills and drains and a long receiver hold.");
        $display("Results: found %0d, inserted %0d, full %0d, saturated %0d, %s %0d, %s %0d, %s %0d.",
                 status_seen[ST_FOUND], status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_SATURATED], "released", status_seen[ST_RELEASED],
                 "freed", status_seen[ST_FREED], "bad release", status_seen[ST_BAD_RELEASE]);
        if (err_cnt == 0 && rsp_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
        begin
            $display("%0d result words were wrong or unexpected.", err_cnt);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/rcit_pkg.sv
src/rcit_req_if.sv
src/rcit_rsp_if.sv
src/rcit_store.sv
src/refcounted_id_table.sv
verif/testbench.sv
